@@ hw/rtl/kstu_pkg.sv @@
// Shared constants and types for the keyed slot table.
// Used by kstu_cell and keyed_slot_table_upsert; no dependencies.
package kstu_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 16;
    localparam int TEMP_W  = 16;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 5;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_UPSERT = 1'b1;

    localparam logic [KEY_W-1:0] KEY_FREE = '0;

    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [KEY_W-1:0]          key_t;
    typedef logic signed [TEMP_W-1:0]  temp_t;
    typedef logic [STAMP_W-1:0]        stamp_t;

    typedef struct packed {
        logic valid;
        key_t key;
        logic hit;
        idx_t hit_idx;
        logic free;
        idx_t free_idx;
    } srch_word_t;

    typedef struct packed {
        logic   en;
        idx_t   idx;
        key_t   key;
        temp_t  temp;
        stamp_t stamp;
    } wr_cmd_t;

endpackage

@@ hw/rtl/keyed_slot_table_upsert.sv @@
// Keyed slot table with lookup and upsert, built as a row of slot cells.
// Depends on kstu_pkg and kstu_cell.
//
// Usage:
//   Command channel (cmd_valid/cmd_stall) carries one word: command, key,
//   temperature, stamp_ms. Command 0 looks up the key; command 1 rewrites
//   temperature and stamp of the lowest slot holding the key, or else fills
//   the lowest free slot (key zero). Key zero matches the lowest free slot.
//   Result channel (res_valid/res_stall) returns found and slot per word;
//   slot is 0 when found is 0, and found is 0 on a miss or a full table.
//   The search word walks the row of ENTRIES cells, one cell per cycle.
//   The result is ready when the word leaves the last cell; the table write
//   lands at that edge, and the result register loads at the same edge
//   unless the output is stalled. One word is in flight at a time, so a
//   new word is taken only once the previous result has been registered.
//   A stalled result is held in the output register; a finished result
//   behind it waits in a hold register and cmd_stall stays high until the
//   output frees up.
//   Reset clears all keys (every slot free) and empties the result channel.
module keyed_slot_table_upsert
    import kstu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  logic                      command,
    input  logic [KEY_W-1:0]          key,
    input  logic signed [TEMP_W-1:0]  temperature,
    input  logic [STAMP_W-1:0]        stamp_ms,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic                      found,
    output logic [SLOT_W-1:0]         slot
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t            state_reg;
    logic              cmd_reg;
    temp_t             temp_reg;
    stamp_t            stamp_reg;
    logic              res_valid_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              hold_found_reg;
    logic [SLOT_W-1:0] hold_slot_reg;

    srch_word_t        chain_head;
    srch_word_t        chain_word [ENTRIES+1];
    srch_word_t        last_word;
    wr_cmd_t           wr;
    logic              accept;
    logic              finish;
    logic              out_free;
    logic              load_res;
    logic              upsert;
    logic              ok;
    idx_t              pos;
    logic [SLOT_W-1:0] pos_slot;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;

    always_comb
    begin
        chain_head       = '0;
        chain_head.valid = accept;
        chain_head.key   = key;
    end

    assign chain_word[0] = chain_head;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            kstu_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (IDX_W'(gi)),
                .word_in    (chain_word[gi]),
                .wr         (wr),
                .word_out   (chain_word[gi+1])
            );
        end
    endgenerate

    assign last_word = chain_word[ENTRIES];
    assign finish    = (state_reg == ST_SCAN) && last_word.valid;
    assign upsert    = (cmd_reg == CMD_UPSERT);
    assign load_res  = out_free && (finish || (state_reg == ST_HOLD));

    always_comb
    begin
        ok  = 1'b0;
        pos = '0;
        if (last_word.hit)
        begin
            ok  = 1'b1;
            pos = last_word.hit_idx;
        end
        else if (upsert && last_word.free)
        begin
            ok  = 1'b1;
            pos = last_word.free_idx;
        end
    end

    assign pos_slot = SLOT_W'(pos);

    always_comb
    begin
        wr.en    = finish && upsert && ok;
        wr.idx   = pos;
        wr.key   = last_word.key;
        wr.temp  = temp_reg;
        wr.stamp = stamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            res_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            slot_reg       <= '0;
            hold_found_reg <= 1'b0;
            hold_slot_reg  <= '0;
            cmd_reg        <= CMD_LOOKUP;
            temp_reg       <= '0;
            stamp_reg      <= '0;
        end
        else
        begin
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= command;
                        temp_reg  <= temperature;
                        stamp_reg <= stamp_ms;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (finish)
                    begin
                        if (out_free)
                        begin
                            found_reg     <= ok;
                            slot_reg      <= pos_slot;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            hold_found_reg <= ok;
                            hold_slot_reg  <= pos_slot;
                            state_reg      <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        found_reg     <= hold_found_reg;
                        slot_reg      <= hold_slot_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign found     = found_reg;
    assign slot      = slot_reg;

endmodule

@@ hw/rtl/kstu_cell.sv @@
// One slot of the keyed slot table: key, temperature and stamp storage.
// Passes the search word to its neighbor each cycle. Depends on kstu_pkg.
module kstu_cell
    import kstu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  idx_t       cell_index,
    input  srch_word_t word_in,
    input  wr_cmd_t    wr,
    output srch_word_t word_out
);

    key_t       key_reg;
    temp_t      temp_reg;
    stamp_t     stamp_reg;
    logic       valid_reg;
    srch_word_t word_reg;
    srch_word_t word_next;
    logic       wr_sel;

    assign wr_sel = wr.en && (wr.idx == cell_index);

    always_comb
    begin
        word_next = word_in;
        if (!word_in.hit && (key_reg == word_in.key))
        begin
            word_next.hit     = 1'b1;
            word_next.hit_idx = cell_index;
        end
        if (!word_in.free && (key_reg == KEY_FREE))
        begin
            word_next.free     = 1'b1;
            word_next.free_idx = cell_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            key_reg   <= KEY_FREE;
        end
        else
        begin
            valid_reg <= word_in.valid;
            if (wr_sel)
            begin
                key_reg <= wr.key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (wr_sel)
        begin
            temp_reg  <= wr.temp;
            stamp_reg <= wr.stamp;
        end
    end

    always_comb
    begin
        word_out       = word_reg;
        word_out.valid = valid_reg;
    end

endmodule

@@ tb/sv/keyed_slot_table_upsert_tb.sv @@
`timescale 1ns / 100ps
// Testbench for keyed_slot_table_upsert: directed and random lookup/upsert words,
// with a scoreboard class that tracks the slot keys and checks every result.
// Depends on kstu_pkg and the keyed_slot_table_upsert RTL.
module keyed_slot_table_upsert_tb;
    import kstu_pkg::*;

    localparam int RANDOM_WORDS = 480;
    localparam int QUIET_WORDS  = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } slot_reply_t;

    class slot_table_board;
        key_t        held_key   [ENTRIES];
        temp_t       held_temp  [ENTRIES];
        stamp_t      held_stamp [ENTRIES];
        slot_reply_t replies_due[$];
        int          failures;
        int          checked;
        int          lookups;
        int          lookup_hits;
        int          upserts;
        int          updates;
        int          inserts;
        int          rejects;

        function new();
            foreach (held_key[i])
            begin
                held_key[i]   = KEY_FREE;
                held_temp[i]  = '0;
                held_stamp[i] = '0;
            end
            failures    = 0;
            checked     = 0;
            lookups     = 0;
            lookup_hits = 0;
            upserts     = 0;
            updates     = 0;
            inserts     = 0;
            rejects     = 0;
        endfunction

        function int lowest_slot(key_t k);
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (held_key[i] == k)
                    return i;
            end
            return ENTRIES;
        endfunction

        function void note_word(logic cmd, key_t k, temp_t t, stamp_t s);
            int          hit;
            slot_reply_t reply;
            hit = lowest_slot(k);
            reply.found = 1'b0;
            reply.slot  = '0;
            if (cmd == CMD_LOOKUP)
            begin
                lookups++;
                if (hit < ENTRIES)
                begin
                    lookup_hits++;
                    reply.found = 1'b1;
                    reply.slot  = SLOT_W'(hit);
                end
            end
            else
            begin
                upserts++;
                if (hit < ENTRIES)
                    updates++;
                else
                begin
                    hit = lowest_slot(KEY_FREE);
                    if (hit < ENTRIES)
                        inserts++;
                    else
                        rejects++;
                end
                if (hit < ENTRIES)
                begin
                    held_key[hit]   = k;
                    held_temp[hit]  = t;
                    held_stamp[hit] = s;
                    reply.found     = 1'b1;
                    reply.slot      = SLOT_W'(hit);
                end
            end
            replies_due.push_back(reply);
        endfunction

        function void check_result(logic f, logic [SLOT_W-1:0] s);
            slot_reply_t want;
            checked++;
            if (replies_due.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result: found=%0b slot=%0d", f, s);
                return;
            end
            want = replies_due.pop_front();
            if (f !== want.found || s !== want.slot)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("mismatch on result %0d: expected found=%0b slot=%0d, got found=%0b slot=%0d",
                             checked, want.found, want.slot, f, s);
            end
        endfunction
    endclass

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cmd_valid   = 1'b0;
    logic              cmd_stall;
    logic              command     = CMD_LOOKUP;
    key_t              key         = '0;
    temp_t             temperature = '0;
    stamp_t            stamp_ms    = '0;
    logic              res_valid;
    logic              res_stall   = 1'b0;
    logic              found;
    logic [SLOT_W-1:0] slot;

    logic              quiet       = 1'b0;
    logic              calm        = 1'b0;
    int                cycle_count = 0;
    slot_table_board   board       = new();

    keyed_slot_table_upsert u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .key         (key),
        .temperature (temperature),
        .stamp_ms    (stamp_ms),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .found       (found),
        .slot        (slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    initial
    begin : result_sink
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                board.check_result(found, slot);
            if (burst > 0)
                burst--;
            else if (!quiet && !calm && $urandom_range(0, 99) < 15)
                burst = $urandom_range(1, 5);
            res_stall <= (burst > 0);
        end
    end

    task automatic send_word(input logic cmd, input key_t k, input temp_t t, input stamp_t s);
        if (!quiet && !calm && $urandom_range(0, 99) < 25)
        begin
            cmd_valid <= 1'b0;
            do
                repeat ($urandom_range(1, 5)) @(posedge clk);
            while ($urandom_range(0, 99) < 75);
        end
        cmd_valid   <= 1'b1;
        command     <= cmd;
        key         <= k;
        temperature <= t;
        stamp_ms    <= s;
        do
            @(posedge clk);
        while (cmd_stall);
        board.note_word(cmd, k, t, s);
    endtask

    task automatic pick_word(input int n, output logic cmd, output key_t k,
                             output temp_t t, output stamp_t s);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            k = KEY_FREE;
        else if (roll < 20)
            k = key_t'($urandom);
        else
            k = key_t'($urandom_range(1, 40));
        cmd = ($urandom_range(0, 99) < ((n < 150) ? 60 : 45)) ? CMD_UPSERT : CMD_LOOKUP;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            t = temp_t'(16'h8000);
        else if (roll < 10)
            t = temp_t'(16'h7fff);
        else
            t = temp_t'($urandom);
        s = stamp_t'($urandom);
    endtask

    initial
    begin : stimulus
        logic   cmd;
        key_t   k;
        temp_t  t;
        stamp_t s;
        int     drain;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: key zero hits slot 0, others miss
        send_word(CMD_LOOKUP, 16'h0000, 16'sd0,      32'h0000_0000);
        send_word(CMD_LOOKUP, 16'hffff, 16'sd0,      32'h0000_0000);
        send_word(CMD_UPSERT, 16'h0000, -16'sd32768, 32'h0000_0000);
        send_word(CMD_LOOKUP, 16'h0000, 16'sd1,      32'hffff_ffff);
        send_word(CMD_UPSERT, 16'hffff, 16'sd32767,  32'hffff_ffff);
        send_word(CMD_UPSERT, 16'h0001, 16'sd0,      32'h0000_0001);
        send_word(CMD_UPSERT, 16'hffff, -16'sd1,     32'h8000_0000);
        send_word(CMD_LOOKUP, 16'hffff, 16'sd0,      32'h0000_0000);
        send_word(CMD_LOOKUP, 16'h0001, 16'sd0,      32'h0000_0000);
        send_word(CMD_LOOKUP, 16'h0000, 16'sd0,      32'h0000_0000);
        send_word(CMD_LOOKUP, 16'h8000, 16'sd0,      32'h0000_0000);
        send_word(CMD_UPSERT, 16'h8000, 16'sh5555,   32'h5555_5555);
        send_word(CMD_UPSERT, 16'h0000, 16'shaaaa,   32'haaaa_aaaa);
        send_word(CMD_LOOKUP, 16'h8000, 16'sd0,      32'h0000_0000);
        send_word(CMD_LOOKUP, 16'h7fff, 16'sd0,      32'h0000_0000);
        send_word(CMD_UPSERT, 16'h0001, 16'sd100,    32'h0000_ffff);
        send_word(CMD_UPSERT, 16'h7fff, -16'sd100,   32'hffff_0000);
        send_word(CMD_LOOKUP, 16'h7fff, 16'sd0,      32'h0000_0000);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            calm  = ((n / 50) % 4 == 3);
            quiet = (n >= RANDOM_WORDS - QUIET_WORDS);
            pick_word(n, cmd, k, t, s);
            send_word(cmd, k, t, s);
        end
        cmd_valid <= 1'b0;

        drain = 0;
        while (board.replies_due.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (ENTRIES + 8) @(posedge clk);
        if (board.replies_due.size() != 0)
        begin
            $display("%0d expected results never arrived", board.replies_due.size());
            board.failures += board.replies_due.size();
        end

        $display("covered %0d lookups (%0d hits) and %0d upserts (%0d updates, %0d inserts, %0d rejected on full table)",
                 board.lookups, board.lookup_hits, board.upserts, board.updates,
                 board.inserts, board.rejects);
        $display("checked %0d results, %0d failures", board.checked, board.failures);
        if (board.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
